// ===== src/pll_multiplier_select_assert.svh =====
// Assertion macros for the PLL multiplier selection block
`ifndef PLL_MULTIPLIER_SELECT_ASSERT_SVH
`define PLL_MULTIPLIER_SELECT_ASSERT_SVH

`ifndef SYNTH

// Check a property on every rising clock edge outside reset
`define PMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Check that a condition implies another one in the same cycle
`define PMS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: implication failed");

`else

`define PMS_ASSERT(lbl, clk, rst_n, prop)
`define PMS_ASSERT_IMP(lbl, clk, rst_n, a, b)

`endif

`endif

// ===== src/pms_pkg.sv =====
package pms_pkg;

    localparam int CLOCK_BITS_DEFAULT = 31;
    localparam int MUL_BITS           = 8;
    localparam int MUL_LIMIT          = 16;
    localparam int HALF_CLOCK_RESET   = 4000000;

endpackage

// ===== src/pms_div_cell.sv =====
module pms_div_cell #(
    parameter int CLOCK_BITS = pms_pkg::CLOCK_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [CLOCK_BITS:0]   in_x,
    input  logic [CLOCK_BITS-1:0] in_rem,
    input  logic [CLOCK_BITS-1:0] in_divisor,
    output logic                  out_valid,
    output logic [CLOCK_BITS:0]   out_x,
    output logic [CLOCK_BITS-1:0] out_rem,
    output logic [CLOCK_BITS-1:0] out_divisor
);

    import pms_pkg::*;

    logic                  valid_reg;
    logic [CLOCK_BITS:0]   x_reg;
    logic [CLOCK_BITS:0]   x_next;
    logic [CLOCK_BITS-1:0] rem_reg;
    logic [CLOCK_BITS-1:0] rem_next;
    logic [CLOCK_BITS-1:0] divisor_reg;
    logic [CLOCK_BITS:0]   trial;
    logic [CLOCK_BITS:0]   diff;
    logic                  fits;

    // one restoring division step: bring down the next dividend bit
    always_comb
    begin
        trial    = {in_rem, in_x[CLOCK_BITS]};
        diff     = trial - {1'b0, in_divisor};
        fits     = trial >= {1'b0, in_divisor};
        rem_next = fits ? diff[CLOCK_BITS-1:0] : trial[CLOCK_BITS-1:0];
        x_next   = {in_x[CLOCK_BITS-1:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        rem_reg     <= rem_next;
        divisor_reg <= in_divisor;
    end

    assign out_valid   = valid_reg;
    assign out_x       = x_reg;
    assign out_rem     = rem_reg;
    assign out_divisor = divisor_reg;

endmodule

// ===== src/pms_select.sv =====
module pms_select #(
    parameter int CLOCK_BITS = pms_pkg::CLOCK_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [CLOCK_BITS:0]           quotient2,
    input  logic [CLOCK_BITS-1:0]         divisor,
    output logic                          done,
    output logic [pms_pkg::MUL_BITS-1:0]  multiplier,
    output logic                          halve_reference,
    output logic [CLOCK_BITS-1:0]         achieved_clock,
    output logic                          zero_reference
);

    import pms_pkg::*;

    logic [CLOCK_BITS-1:0]      q;
    logic                       q2_odd;
    logic                       big;
    logic                       halve;
    logic                       zero;
    logic [MUL_BITS-1:0]        mul;

    logic                       valid_reg;
    logic [MUL_BITS-1:0]        mul_reg;
    logic                       halve_reg;
    logic                       zero_reg;
    logic [CLOCK_BITS-1:0]      ref_reg;

    logic [CLOCK_BITS+MUL_BITS-1:0] prod;
    logic [CLOCK_BITS-1:0]      achieved_next;

    logic                       done_reg;
    logic [MUL_BITS-1:0]        multiplier_reg;
    logic                       halve_out_reg;
    logic [CLOCK_BITS-1:0]      achieved_reg;
    logic                       zero_out_reg;

    // halving wins exactly when 2*target/ref is odd, the plain quotient is small
    // and half the reference is not zero
    always_comb
    begin
        q      = quotient2[CLOCK_BITS:1];
        q2_odd = quotient2[0];
        big    = q > CLOCK_BITS'(MUL_LIMIT);
        zero   = divisor == '0;
        halve  = !zero && q2_odd && !big && (divisor[CLOCK_BITS-1:1] != '0);
        priority if (zero)
            mul = '0;
        else if (halve)
            mul = {q[MUL_BITS-2:0], 1'b1};
        else
            mul = q[MUL_BITS-1:0];
    end

    always_comb
    begin
        prod = (CLOCK_BITS+MUL_BITS)'(mul_reg) * (CLOCK_BITS+MUL_BITS)'(ref_reg);
        achieved_next = halve_reg ? prod[CLOCK_BITS:1] : prod[CLOCK_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg        <= mul;
        halve_reg      <= halve;
        zero_reg       <= zero;
        ref_reg        <= divisor;
        multiplier_reg <= mul_reg;
        halve_out_reg  <= halve_reg;
        achieved_reg   <= achieved_next;
        zero_out_reg   <= zero_reg;
    end

    assign done            = done_reg;
    assign multiplier      = multiplier_reg;
    assign halve_reference = halve_out_reg;
    assign achieved_clock  = achieved_reg;
    assign zero_reference  = zero_out_reg;

endmodule

// ===== src/pll_multiplier_select.sv =====
// PLL multiplier selection. Pulse start with a target clock, a reference select
// and the external rate; a new transaction is taken in every cycle (busy stays
// low) and its result appears on the result ports for one cycle under done, in
// order, after passing a row of CLOCK_BITS+1 division cells, one quotient bit
// each, then a selection register and a register after the multiply that forms
// achieved_clock. The receiver cannot stall: take each result in the cycle done
// is high. Write internal_half_clock through write_enable/write_data only while
// no transaction is in flight.
`include "pll_multiplier_select_assert.svh"

module pll_multiplier_select #(
    parameter int CLOCK_BITS = pms_pkg::CLOCK_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [CLOCK_BITS-1:0]         target_clock,
    input  logic                          use_external,
    input  logic [CLOCK_BITS-1:0]         external_clock,
    input  logic                          write_enable,
    input  logic [CLOCK_BITS-1:0]         write_data,
    output logic                          done,
    output logic [pms_pkg::MUL_BITS-1:0]  multiplier,
    output logic                          halve_reference,
    output logic [CLOCK_BITS-1:0]         achieved_clock,
    output logic                          zero_reference
);

    import pms_pkg::*;

    localparam int STEPS   = CLOCK_BITS + 1;
    localparam int LATENCY = CLOCK_BITS + 3;

    logic [CLOCK_BITS-1:0] internal_half_clock_reg;

    logic                  valid_w   [0:STEPS];
    logic [CLOCK_BITS:0]   x_w       [0:STEPS];
    logic [CLOCK_BITS-1:0] rem_w     [0:STEPS];
    logic [CLOCK_BITS-1:0] divisor_w [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            internal_half_clock_reg <= CLOCK_BITS'(HALF_CLOCK_RESET);
        end
        else if (write_enable)
        begin
            internal_half_clock_reg <= write_data;
        end
    end

    assign busy = 1'b0;

    // divide 2*target by the reference: the extra low step yields the doubled quotient
    assign valid_w[0]   = start && !busy;
    assign x_w[0]       = {target_clock, 1'b0};
    assign rem_w[0]     = '0;
    assign divisor_w[0] = use_external ? external_clock : internal_half_clock_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        pms_div_cell #(
            .CLOCK_BITS (CLOCK_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (valid_w[i]),
            .in_x        (x_w[i]),
            .in_rem      (rem_w[i]),
            .in_divisor  (divisor_w[i]),
            .out_valid   (valid_w[i+1]),
            .out_x       (x_w[i+1]),
            .out_rem     (rem_w[i+1]),
            .out_divisor (divisor_w[i+1])
        );
    end

    pms_select #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_select (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (valid_w[STEPS]),
        .quotient2       (x_w[STEPS]),
        .divisor         (divisor_w[STEPS]),
        .done            (done),
        .multiplier      (multiplier),
        .halve_reference (halve_reference),
        .achieved_clock  (achieved_clock),
        .zero_reference  (zero_reference)
    );

    `PMS_ASSERT(a_done_follows_start, clk, rst_n, done |-> $past(start, LATENCY))
    `PMS_ASSERT(a_start_gives_done, clk, rst_n, start |-> ##LATENCY done)
    `PMS_ASSERT_IMP(a_zero_clears, clk, rst_n, done && zero_reference,
        multiplier == '0 && !halve_reference && achieved_clock == '0)
    `PMS_ASSERT_IMP(a_halve_small_odd, clk, rst_n, done && halve_reference,
        multiplier[0] && multiplier <= MUL_BITS'(2 * MUL_LIMIT + 1) && !zero_reference)

endmodule
